### src/srpg_pkg.sv
// Shared types and constants for the stepper ramp pulse generator.
// Depends on nothing; imported by the top level.
package srpg_pkg;

   // Widths fixed by the register map and the response fields
   localparam int SPEED_W    = 24;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   // Defaults for the top-level parameters
   localparam int DEF_SPEED_FRAC_BITS  = 8;
   localparam int DEF_INTERVAL_WIDTH   = 24;
   localparam int DEF_TICKS_PER_SECOND = 1000000;

   // Register indexes (word address bit 2)
   localparam logic REG_TARGET_SPEED    = 1'b0;
   localparam logic REG_SPEED_INCREMENT = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EVAL,
      ST_RAMP,
      ST_DIVIDE,
      ST_FINISH,
      ST_PUSH
   } state_type;

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_HIGH,
      PH_LOW
   } phase_type;

endpackage

### src/stepper_ramp_pulse_generator.sv
// Top level of the stepper ramp pulse generator: sequencer, ramp, serial divider,
// register port and response register. Depends on srpg_pkg.
//
// Usage
//   Each request on the req_ channel is one tick of the step time base and carries
//   req_run. Each request yields exactly one response on the rsp_ channel with the
//   step and direction pin levels for that tick, a step-start flag, the current
//   step interval in ticks and the current ramped speed (unsigned 16.8).
//   target_speed sits at byte address 0 and speed_increment at byte address 4 of
//   the APB-style register port; writes take effect at the next step start.
// Sequencing and throughput
//   One request is in work at a time; req_ready is high only while idle.
//   A tick inside a pulse passes from ST_EVAL to ST_PUSH, which loads its response.
//   A tick that starts a step runs the speed ramp and then a restoring divider
//   that produces one quotient bit per cycle over DIV_BITS bits, the width of
//   TICKS_PER_SECOND shifted left by SPEED_FRAC_BITS; ST_FINISH then sets the
//   interval and ST_PUSH loads the response.
//   The next request can be taken in the cycle after the response is loaded.
// Reset and stall
//   reset (synchronous, active high) clears speed, interval, pulse phase and both
//   registers. A stalled receiver holds the response register; the block still
//   takes one more request and works it, then holds it until the register frees.
module stepper_ramp_pulse_generator
   import srpg_pkg::*;
#(
   parameter int SPEED_FRAC_BITS  = DEF_SPEED_FRAC_BITS,
   parameter int INTERVAL_WIDTH   = DEF_INTERVAL_WIDTH,
   parameter int TICKS_PER_SECOND = DEF_TICKS_PER_SECOND
) (
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_run,
   // response channel
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic                  rsp_step_level,
   output logic                  rsp_dir_level,
   output logic                  rsp_step_begins,
   output logic [SPEED_W-1:0]    rsp_interval_us,
   output logic [SPEED_W-1:0]    rsp_speed_now,
   // register port
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   // Dividend width and value: TICKS_PER_SECOND in speed fixed point
   localparam int DIV_BITS = $clog2(TICKS_PER_SECOND + 1) + SPEED_FRAC_BITS;
   localparam int CNT_W    = $clog2(DIV_BITS);
   localparam int CD_W     = INTERVAL_WIDTH - 1;
   localparam logic [DIV_BITS-1:0] DIVIDEND =
      DIV_BITS'(64'(TICKS_PER_SECOND) << SPEED_FRAC_BITS);

   state_type                  state_ff, state_in;
   phase_type                  phase_ff, phase_in;
   logic [CD_W-1:0]            cd_ff, cd_in;
   logic [SPEED_W-1:0]         speed_ff, speed_in;
   logic [INTERVAL_WIDTH-1:0]  interval_ff, interval_in;
   logic [SPEED_W-1:0]         target_ff, target_in;
   logic [SPEED_W-1:0]         incr_ff, incr_in;
   logic                       run_ff, run_in;
   logic                       pend_step_ff, pend_step_in;
   logic                       pend_dir_ff, pend_dir_in;
   logic                       pend_begins_ff, pend_begins_in;
   logic [SPEED_W-1:0]         rem_ff, rem_in;
   logic [DIV_BITS-1:0]        quot_ff, quot_in;
   logic [CNT_W-1:0]           cnt_ff, cnt_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic                       rsp_step_ff, rsp_step_in;
   logic                       rsp_dir_ff, rsp_dir_in;
   logic                       rsp_begins_ff, rsp_begins_in;
   logic [SPEED_W-1:0]         rsp_interval_ff, rsp_interval_in;
   logic [SPEED_W-1:0]         rsp_speed_ff, rsp_speed_in;

   logic                       csr_write;
   logic [SPEED_W:0]           ramp_sum;
   logic [SPEED_W-1:0]         ramp_speed;
   logic [SPEED_W:0]           rem_shift;
   logic                       div_ge;
   logic                       quot_ovf;
   logic [INTERVAL_WIDTH-1:0]  quot_sat;
   logic [31:0]                interval_wide;

   // Half interval less one, with a half of zero raised to one tick
   function automatic logic [CD_W-1:0] half_minus_one(input logic [INTERVAL_WIDTH-1:0] iv);
      logic [CD_W-1:0] h;
      h = iv[INTERVAL_WIDTH-1:1];
      if (h == '0) begin
         return '0;
      end
      return h - CD_W'(1);
   endfunction

   // ---------------------------------------------------------------- register port
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   always_comb begin
      case (paddr[2])
         REG_TARGET_SPEED:    prdata = CSR_DATA_W'(target_ff);
         REG_SPEED_INCREMENT: prdata = CSR_DATA_W'(incr_ff);
         default:             prdata = '0;
      endcase
   end

   always_comb begin
      target_in = target_ff;
      incr_in   = incr_ff;
      if (csr_write) begin
         case (paddr[2])
            REG_TARGET_SPEED:    target_in = pwdata[SPEED_W-1:0];
            REG_SPEED_INCREMENT: incr_in   = pwdata[SPEED_W-1:0];
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------- datapath pieces
   // Move the speed toward the target by the increment, never past it
   assign ramp_sum = {1'b0, speed_ff} + {1'b0, incr_ff};
   always_comb begin
      ramp_speed = speed_ff;
      if (speed_ff < target_ff) begin
         ramp_speed = (ramp_sum > {1'b0, target_ff}) ? target_ff : ramp_sum[SPEED_W-1:0];
      end else if (speed_ff > target_ff) begin
         if (incr_ff > speed_ff || (speed_ff - incr_ff) < target_ff) begin
            ramp_speed = target_ff;
         end else begin
            ramp_speed = speed_ff - incr_ff;
         end
      end
   end

   // One restoring divide step per cycle; the remainder always stays below the speed
   assign rem_shift = {rem_ff, quot_ff[DIV_BITS-1]};
   assign div_ge    = rem_shift >= {1'b0, speed_ff};

   // Saturate the finished quotient at the interval width
   assign quot_ovf = |(quot_ff >> INTERVAL_WIDTH);
   assign quot_sat = quot_ovf ? '1 : INTERVAL_WIDTH'(quot_ff);

   assign interval_wide = 32'(interval_ff);

   // ---------------------------------------------------------------- sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= PH_IDLE;
         cd_ff        <= '0;
         speed_ff     <= '0;
         interval_ff  <= '0;
         target_ff    <= '0;
         incr_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         cd_ff        <= cd_in;
         speed_ff     <= speed_in;
         interval_ff  <= interval_in;
         target_ff    <= target_in;
         incr_ff      <= incr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      run_ff          <= run_in;
      pend_step_ff    <= pend_step_in;
      pend_dir_ff     <= pend_dir_in;
      pend_begins_ff  <= pend_begins_in;
      rem_ff          <= rem_in;
      quot_ff         <= quot_in;
      cnt_ff          <= cnt_in;
      rsp_step_ff     <= rsp_step_in;
      rsp_dir_ff      <= rsp_dir_in;
      rsp_begins_ff   <= rsp_begins_in;
      rsp_interval_ff <= rsp_interval_in;
      rsp_speed_ff    <= rsp_speed_in;
   end

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in        = state_ff;
      phase_in        = phase_ff;
      cd_in           = cd_ff;
      speed_in        = speed_ff;
      interval_in     = interval_ff;
      run_in          = run_ff;
      pend_step_in    = pend_step_ff;
      pend_dir_in     = pend_dir_ff;
      pend_begins_in  = pend_begins_ff;
      rem_in          = rem_ff;
      quot_in         = quot_ff;
      cnt_in          = cnt_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_ready;
      rsp_step_in     = rsp_step_ff;
      rsp_dir_in      = rsp_dir_ff;
      rsp_begins_in   = rsp_begins_ff;
      rsp_interval_in = rsp_interval_ff;
      rsp_speed_in    = rsp_speed_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               run_in   = req_run;
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            pend_step_in   = 1'b0;
            pend_dir_in    = run_ff;
            pend_begins_in = 1'b0;
            state_in       = ST_PUSH;
            if (!run_ff) begin
               // stop: drop the pulse, keep speed and interval
               phase_in = PH_IDLE;
               cd_in    = '0;
            end else begin
               case (phase_ff)
                  PH_HIGH: begin
                     if (cd_ff != '0) begin
                        cd_in        = cd_ff - CD_W'(1);
                        pend_step_in = 1'b1;
                     end else begin
                        phase_in = PH_LOW;
                        cd_in    = half_minus_one(interval_ff);
                     end
                  end
                  PH_LOW: begin
                     if (cd_ff != '0) begin
                        cd_in = cd_ff - CD_W'(1);
                     end else begin
                        state_in = ST_RAMP;
                     end
                  end
                  default: state_in = ST_RAMP;
               endcase
            end
         end
         ST_RAMP: begin
            speed_in = ramp_speed;
            if (ramp_speed == '0) begin
               // no pulse at zero speed; retry on the next running tick
               interval_in = '1;
               phase_in    = PH_IDLE;
               cd_in       = '0;
               state_in    = ST_PUSH;
            end else begin
               rem_in   = '0;
               quot_in  = DIVIDEND;
               cnt_in   = CNT_W'(DIV_BITS - 1);
               state_in = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            rem_in  = div_ge ? SPEED_W'(rem_shift - {1'b0, speed_ff}) : rem_shift[SPEED_W-1:0];
            quot_in = {quot_ff[DIV_BITS-2:0], div_ge};
            if (cnt_ff == '0) begin
               state_in = ST_FINISH;
            end else begin
               cnt_in = cnt_ff - CNT_W'(1);
            end
         end
         ST_FINISH: begin
            interval_in    = quot_sat;
            phase_in       = PH_HIGH;
            cd_in          = half_minus_one(quot_sat);
            pend_step_in   = 1'b1;
            pend_begins_in = 1'b1;
            state_in       = ST_PUSH;
         end
         ST_PUSH: begin
            // hold until the response register is free or being taken
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in    = 1'b1;
               rsp_step_in     = pend_step_ff;
               rsp_dir_in      = pend_dir_ff;
               rsp_begins_in   = pend_begins_ff;
               rsp_interval_in = interval_wide[SPEED_W-1:0];
               rsp_speed_in    = speed_ff;
               state_in        = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_step_level  = rsp_step_ff;
   assign rsp_dir_level   = rsp_dir_ff;
   assign rsp_step_begins = rsp_begins_ff;
   assign rsp_interval_us = rsp_interval_ff;
   assign rsp_speed_now   = rsp_speed_ff;

   // ---------------------------------------------------------------- checks
   a_begin_drives_pins: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_begins_ff |-> rsp_step_ff && rsp_dir_ff)
      else $error("step start without step and direction high");

   a_divisor_nonzero: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIVIDE |-> speed_ff != '0)
      else $error("divider running on zero speed");

   a_remainder_bounded: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIVIDE |-> rem_ff < speed_ff)
      else $error("divider remainder not below divisor");

   a_pulse_needs_speed: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_HIGH |-> speed_ff != '0)
      else $error("pulse high at zero speed");

   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> state_ff == ST_EVAL)
      else $error("request accepted but not evaluated");

endmodule

### tb/sv/srpg_tick_checker.sv
`timescale 1ns / 100ps
// Watches the request, response and register ports of the stepper ramp pulse generator.
// Predicts each tick's pin levels, interval and speed, and compares responses in order.
// Depends on srpg_pkg.
module srpg_tick_checker
   import srpg_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_ready,
   input  logic                  req_run,
   input  logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  logic                  rsp_step_level,
   input  logic                  rsp_dir_level,
   input  logic                  rsp_step_begins,
   input  logic [SPEED_W-1:0]    rsp_interval_us,
   input  logic [SPEED_W-1:0]    rsp_speed_now,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   input  logic [CSR_DATA_W-1:0] prdata,
   input  logic                  pready,
   output int                    fail_count,
   output int                    open_ticks,
   output int                    ticks_checked,
   output int                    steps_seen
);

   localparam longint unsigned TICK_SCALE =
      longint'(DEF_TICKS_PER_SECOND) << DEF_SPEED_FRAC_BITS;
   localparam longint unsigned INTERVAL_SAT = (64'd1 << DEF_INTERVAL_WIDTH) - 1;

   typedef struct packed {
      logic               step_level;
      logic               dir_level;
      logic               step_begins;
      logic [SPEED_W-1:0] interval_us;
      logic [SPEED_W-1:0] speed_now;
   } tick_levels_type;

   // predictor copy of the block's registers and state
   logic [SPEED_W-1:0] target_reg;
   logic [SPEED_W-1:0] increment_reg;
   logic [SPEED_W-1:0] speed_q;
   logic [SPEED_W-1:0] interval_q;
   logic [22:0]        countdown_q;
   phase_type          pulse_q;

   tick_levels_type levels_due[$];

   function automatic logic [22:0] half_less_one(logic [SPEED_W-1:0] ivl);
      logic [22:0] h;
      h = ivl[SPEED_W-1:1];
      if (h == '0)
         h = 23'd1;
      return h - 23'd1;
   endfunction

   // move the speed toward the target without overshooting it
   function automatic logic [SPEED_W-1:0] ramped(logic [SPEED_W-1:0] s,
                                                 logic [SPEED_W-1:0] t,
                                                 logic [SPEED_W-1:0] a);
      logic [SPEED_W:0] up;
      up = {1'b0, s} + {1'b0, a};
      if (s < t)
         return (up > {1'b0, t}) ? t : up[SPEED_W-1:0];
      if (s > t)
         return (a > s || (s - a) < t) ? t : s - a;
      return s;
   endfunction

   function automatic logic [SPEED_W-1:0] interval_for(logic [SPEED_W-1:0] spd);
      longint unsigned q;
      if (spd == '0)
         return INTERVAL_SAT[SPEED_W-1:0];
      q = TICK_SCALE / longint'(spd);
      if (q > INTERVAL_SAT)
         q = INTERVAL_SAT;
      return q[SPEED_W-1:0];
   endfunction

   function automatic tick_levels_type advance_pulse_train(logic run);
      tick_levels_type lv;
      lv = '0;
      if (!run) begin
         pulse_q     = PH_IDLE;
         countdown_q = '0;
      end else begin
         lv.dir_level = 1'b1;
         if (pulse_q == PH_HIGH) begin
            if (countdown_q != '0) begin
               countdown_q   = countdown_q - 23'd1;
               lv.step_level = 1'b1;
            end else begin
               pulse_q     = PH_LOW;
               countdown_q = half_less_one(interval_q);
            end
         end else if (pulse_q == PH_LOW && countdown_q != '0) begin
            countdown_q = countdown_q - 23'd1;
         end else begin
            // step start: ramp, then derive the new interval
            speed_q    = ramped(speed_q, target_reg, increment_reg);
            interval_q = interval_for(speed_q);
            if (speed_q == '0) begin
               pulse_q     = PH_IDLE;
               countdown_q = '0;
            end else begin
               pulse_q        = PH_HIGH;
               countdown_q    = half_less_one(interval_q);
               lv.step_level  = 1'b1;
               lv.step_begins = 1'b1;
            end
         end
      end
      lv.interval_us = interval_q;
      lv.speed_now   = speed_q;
      return lv;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      fail_count++;
      $display("[%0t] mismatch on %s: got %0h, expected %0h", $time, what, got, want);
   endtask

   task automatic compare_tick(tick_levels_type want);
      if (rsp_step_level !== want.step_level)
         report_mismatch("step_level", 32'(rsp_step_level), 32'(want.step_level));
      if (rsp_dir_level !== want.dir_level)
         report_mismatch("dir_level", 32'(rsp_dir_level), 32'(want.dir_level));
      if (rsp_step_begins !== want.step_begins)
         report_mismatch("step_begins", 32'(rsp_step_begins), 32'(want.step_begins));
      if (rsp_interval_us !== want.interval_us)
         report_mismatch("interval_us", 32'(rsp_interval_us), 32'(want.interval_us));
      if (rsp_speed_now !== want.speed_now)
         report_mismatch("speed_now", 32'(rsp_speed_now), 32'(want.speed_now));
   endtask

   initial begin
      fail_count    = 0;
      open_ticks    = 0;
      ticks_checked = 0;
      steps_seen    = 0;
   end

   always @(posedge clock) begin
      if (reset) begin
         target_reg    = '0;
         increment_reg = '0;
         speed_q       = '0;
         interval_q    = '0;
         countdown_q   = '0;
         pulse_q       = PH_IDLE;
         levels_due.delete();
      end else begin
         if (psel && penable && pready) begin
            if (pwrite) begin
               if (paddr[CSR_ADDR_W-1:2] == REG_TARGET_SPEED)
                  target_reg = pwdata[SPEED_W-1:0];
               else if (paddr[CSR_ADDR_W-1:2] == REG_SPEED_INCREMENT)
                  increment_reg = pwdata[SPEED_W-1:0];
            end else if (paddr[CSR_ADDR_W-1:2] == REG_TARGET_SPEED) begin
               if (prdata[SPEED_W-1:0] !== target_reg)
                  report_mismatch("target_speed read", prdata, 32'(target_reg));
            end else if (prdata[SPEED_W-1:0] !== increment_reg) begin
               report_mismatch("speed_increment read", prdata, 32'(increment_reg));
            end
         end
         // retire before predicting: a response never belongs to this edge's request
         if (rsp_valid && rsp_ready) begin
            if (levels_due.size() == 0) begin
               report_mismatch("unexpected response", 32'd1, 32'd0);
            end else begin
               compare_tick(levels_due.pop_front());
               ticks_checked++;
               if (rsp_step_begins === 1'b1)
                  steps_seen++;
            end
         end
         if (req_valid && req_ready)
            levels_due.push_back(advance_pulse_train(req_run));
      end
      open_ticks = levels_due.size();
   end

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 100ps
// Stimulus and verdict for the stepper ramp pulse generator.
// Depends on srpg_pkg, stepper_ramp_pulse_generator and srpg_tick_checker.
module tb_top
   import srpg_pkg::*;
();

   localparam int RANDOM_TICKS = 650;
   localparam int HOLD_CYCLES  = 300;
   localparam int END_LATENCY  = 40;
   localparam int CYCLE_LIMIT  = 400000;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   logic                  req_run;
   logic                  rsp_valid;
   logic                  rsp_ready;
   logic                  rsp_step_level;
   logic                  rsp_dir_level;
   logic                  rsp_step_begins;
   logic [SPEED_W-1:0]    rsp_interval_us;
   logic [SPEED_W-1:0]    rsp_speed_now;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   int fail_count;
   int open_ticks;
   int ticks_checked;
   int steps_seen;

   // stimulus bookkeeping
   int ticks_sent;
   int stop_ticks;
   int reg_writes;
   int reg_reads;
   int settings_used;
   int cycle_count;

   // idling controls for the sender and the receiver
   logic steady;
   logic hold_request;
   logic hold_used;
   int   hold_left;

   stepper_ramp_pulse_generator DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_run         (req_run),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_step_level  (rsp_step_level),
      .rsp_dir_level   (rsp_dir_level),
      .rsp_step_begins (rsp_step_begins),
      .rsp_interval_us (rsp_interval_us),
      .rsp_speed_now   (rsp_speed_now),
      .psel            (psel),
      .penable         (penable),
      .pwrite          (pwrite),
      .paddr           (paddr),
      .pwdata          (pwdata),
      .prdata          (prdata),
      .pready          (pready)
   );

   srpg_tick_checker CHK (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_run         (req_run),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_step_level  (rsp_step_level),
      .rsp_dir_level   (rsp_dir_level),
      .rsp_step_begins (rsp_step_begins),
      .rsp_interval_us (rsp_interval_us),
      .rsp_speed_now   (rsp_speed_now),
      .psel            (psel),
      .penable         (penable),
      .pwrite          (pwrite),
      .paddr           (paddr),
      .pwdata          (pwdata),
      .prdata          (prdata),
      .pready          (pready),
      .fail_count      (fail_count),
      .open_ticks      (open_ticks),
      .ticks_checked   (ticks_checked),
      .steps_seen      (steps_seen)
   );

   // 10 ns clock
   initial clock = 1'b0;
   always #5 clock = ~clock;

   // Hard stop: the slowest legal run is far below this many cycles.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d responses outstanding",
                  cycle_count, open_ticks);
         $display("== FAIL ==");
         $finish;
      end
   end

   // Receiver: drop ready at random, with a chance of 17 percent, never while steady, and
   // hold it low for one long stretch when asked so the block backs up.
   always @(negedge clock) begin
      if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else if (hold_request && !hold_used) begin
         hold_left <= HOLD_CYCLES;
         hold_used <= 1'b1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= steady || ($urandom_range(0, 99) >= 17);
      end
   end

   // Offer one tick request; return at the falling edge after it was taken.
   // Valid stays high from one request to the next unless a gap is drawn.
   task automatic send_tick(input logic run);
      if (!steady && $urandom_range(0, 99) < 17) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_run   <= run;
      // ready only moves on a rising edge, so it is stable here
      while (!req_ready) @(negedge clock);
      @(negedge clock);
      ticks_sent++;
      if (!run)
         stop_ticks++;
   endtask

   // Close a burst: drop valid and wait until every response is back.
   task automatic drain;
      req_valid <= 1'b0;
      while (open_ticks != 0) @(negedge clock);
   endtask

   // Setup then access phase; junk in the upper data bits must be ignored.
   task automatic write_reg(input logic idx, input logic [SPEED_W-1:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= {8'($urandom), value};
      @(negedge clock);
      penable <= 1'b1;
      while (!pready) @(negedge clock);
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      reg_writes++;
   endtask

   // The checker compares prdata against its own register copy.
   task automatic read_reg(input logic idx);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= {idx, 2'b00};
      @(negedge clock);
      penable <= 1'b1;
      while (!pready) @(negedge clock);
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      reg_reads++;
   endtask

   task automatic set_speeds(input logic [SPEED_W-1:0] tgt, input logic [SPEED_W-1:0] inc);
      write_reg(REG_TARGET_SPEED, tgt);
      write_reg(REG_SPEED_INCREMENT, inc);
      settings_used++;
   endtask

   initial begin
      int                 phase_len;
      int                 pick;
      int                 ph;
      logic               noisy;
      logic               wr_target;
      logic               wr_incr;
      logic [SPEED_W-1:0] tgt;
      logic [SPEED_W-1:0] inc;

      // every input known from time zero
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_run       = 1'b0;
      rsp_ready     = 1'b0;
      psel          = 1'b0;
      penable       = 1'b0;
      pwrite        = 1'b0;
      paddr         = '0;
      pwdata        = '0;
      steady        = 1'b0;
      hold_request  = 1'b0;
      hold_used     = 1'b0;
      hold_left     = 0;
      cycle_count   = 0;
      ticks_sent    = 0;
      stop_ticks    = 0;
      reg_writes    = 0;
      reg_reads     = 0;
      settings_used = 1;

      repeat (9) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: reset registers give zero speed, so running ticks try a
      // start every time, give no pulse and show the saturated interval.
      send_tick(1'b1);
      send_tick(1'b1);
      send_tick(1'b0);
      send_tick(1'b1);
      drain();

      // Both registers at their maximum: speed jumps straight to the top,
      // shortest interval; run a full high and part of the low phase, then
      // stop and restart at once.
      set_speeds('1, '1);
      read_reg(REG_TARGET_SPEED);
      read_reg(REG_SPEED_INCREMENT);
      repeat (9) send_tick(1'b1);
      send_tick(1'b0);
      repeat (3) send_tick(1'b1);
      drain();

      // Ramp down toward the smallest nonzero target: first a plain decrement,
      // then an increment larger than the speed clamps at the target, whose
      // quotient overflows the interval width.
      set_speeds(24'd1, 24'h800000);
      send_tick(1'b0);
      send_tick(1'b1);
      send_tick(1'b0);
      send_tick(1'b1);
      drain();

      // Zero increment below the target: speed holds.
      write_reg(REG_SPEED_INCREMENT, '0);
      write_reg(REG_TARGET_SPEED, '1);
      settings_used++;
      send_tick(1'b0);
      send_tick(1'b1);
      drain();

      // Random phases: mostly long running stretches with the odd stop, some
      // noisy phases, one phase with no idling and one long receiver hold-off.
      ph = 0;
      while (ticks_sent < RANDOM_TICKS + 23) begin
         pick = $urandom_range(0, 99);
         if (pick < 65)
            tgt = SPEED_W'($urandom_range(24'hA00000, 24'hFFFFFF));
         else if (pick < 82)
            tgt = SPEED_W'($urandom);
         else if (pick < 92)
            tgt = '0;
         else
            tgt = '1;
         pick = $urandom_range(0, 99);
         if (pick < 35)
            inc = SPEED_W'($urandom_range(1, 24'h3FFF));
         else if (pick < 65)
            inc = SPEED_W'($urandom);
         else if (pick < 80)
            inc = '0;
         else if (pick < 90)
            inc = '1;
         else
            inc = SPEED_W'($urandom_range(24'h100000, 24'h800000));

         wr_target = ($urandom_range(0, 4) != 0);
         wr_incr   = ($urandom_range(0, 4) != 0);
         if (!wr_target && !wr_incr)
            wr_target = 1'b1;
         if (wr_target)
            write_reg(REG_TARGET_SPEED, tgt);
         if (wr_incr)
            write_reg(REG_SPEED_INCREMENT, inc);
         settings_used++;
         if ($urandom_range(0, 1) == 1) begin
            read_reg(REG_TARGET_SPEED);
            read_reg(REG_SPEED_INCREMENT);
         end

         steady <= (ph == 3);
         if (ph == 6)
            hold_request <= 1'b1;

         noisy     = ($urandom_range(0, 4) == 0);
         phase_len = $urandom_range(20, 60);
         repeat (phase_len) begin
            if (noisy)
               send_tick(1'($urandom_range(0, 1)));
            else
               send_tick($urandom_range(0, 99) >= 8);
         end
         drain();
         ph++;
      end

      steady <= 1'b0;
      repeat (END_LATENCY) @(negedge clock);

      $display("Covered %0d tick requests (%0d stop ticks, %0d step starts) over %0d settings.",
               ticks_sent, stop_ticks, steps_seen, settings_used);
      $display("Register traffic: %0d writes, %0d read-backs; %0d responses checked.",
               reg_writes, reg_reads, ticks_checked);
      if (fail_count == 0 && open_ticks == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
